@@ rtl/assert_macros.svh @@
// Assertion macros for the command frame builder, compiled out under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define CFB_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define CFB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define CFB_ASSERT(lbl, clk, rst_n, prop, msg)

`define CFB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ rtl/cfb_pkg.sv @@
// Shared constants, types and the CRC-16 byte update for the command frame builder.
`default_nettype none

package cfb_pkg;

  localparam int MAX_PAYLOAD = 249;
  localparam int REM_W = $clog2(MAX_PAYLOAD + 1);

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h8005;
  localparam logic [15:0] CRC_TOP = 16'h8000;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_STRAY  = 2'd1,
    ERR_LENGTH = 2'd2
  } err_t;

  typedef enum logic [1:0] {
    KIND_START,
    KIND_DATA,
    KIND_STRAY,
    KIND_LENGTH
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] cmd;
    logic [15:0] len;
    logic [7:0]  pbyte;
    logic        close;
  } entry_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if ((c & CRC_TOP) != 16'h0000) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/cfb_front.sv @@
// Front end: accepts input words, tracks the open frame and classifies each word.
`default_nettype none

module cfb_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic                in_opcode,
  input  wire logic [15:0]         in_command_code,
  input  wire logic [15:0]         in_payload_length,
  input  wire logic [7:0]          in_payload_byte,
  input  wire logic                q_full,
  output logic                     q_push,
  output cfb_pkg::entry_t          q_entry
);

  logic                      open_r;
  logic                      open_nxt;
  logic [cfb_pkg::REM_W-1:0] rem_r;
  logic [cfb_pkg::REM_W-1:0] rem_nxt;

  assign in_stall = q_full;
  assign q_push = in_valid && !q_full;

  always_comb begin
    open_nxt = open_r;
    rem_nxt = rem_r;
    q_entry.kind = cfb_pkg::KIND_STRAY;
    q_entry.cmd = in_command_code;
    q_entry.len = in_payload_length;
    q_entry.pbyte = in_payload_byte;
    q_entry.close = 1'b0;
    if (!in_opcode) begin
      if (in_payload_length > 16'(cfb_pkg::MAX_PAYLOAD)) begin
        q_entry.kind = cfb_pkg::KIND_LENGTH;
        open_nxt = 1'b0;
        rem_nxt = '0;
      end else begin
        q_entry.kind = cfb_pkg::KIND_START;
        q_entry.close = (in_payload_length == 16'h0000);
        open_nxt = (in_payload_length != 16'h0000);
        rem_nxt = in_payload_length[cfb_pkg::REM_W-1:0];
      end
    end else if (open_r) begin
      q_entry.kind = cfb_pkg::KIND_DATA;
      q_entry.close = (rem_r == cfb_pkg::REM_W'(1));
      rem_nxt = rem_r - cfb_pkg::REM_W'(1);
      if (rem_r == cfb_pkg::REM_W'(1)) begin
        open_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 1'b0;
      rem_r <= '0;
    end else if (q_push) begin
      open_r <= open_nxt;
      rem_r <= rem_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/cfb_queue.sv @@
// Short queue of classified words between the front end and the byte sequencer.
`default_nettype none

module cfb_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire cfb_pkg::entry_t  push_entry,
  input  wire logic             pop,
  output cfb_pkg::entry_t       head,
  output logic                  head_valid,
  output logic                  full
);

  cfb_pkg::entry_t            slots_r [cfb_pkg::QDEPTH];
  logic [cfb_pkg::QPTR_W-1:0] wr_ptr_r;
  logic [cfb_pkg::QPTR_W-1:0] rd_ptr_r;
  logic [cfb_pkg::QPTR_W:0]   count_r;
  logic [cfb_pkg::QPTR_W:0]   count_nxt;

  assign head = slots_r[rd_ptr_r];
  assign head_valid = (count_r != '0);
  assign full = (count_r == (cfb_pkg::QPTR_W + 1)'(cfb_pkg::QDEPTH));

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + (cfb_pkg::QPTR_W + 1)'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - (cfb_pkg::QPTR_W + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_entry;
    end
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + cfb_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + cfb_pkg::QPTR_W'(1);
      end
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/cfb_back.sv @@
// Back end: expands each queued word into frame bytes and keeps the running CRC.
`default_nettype none

module cfb_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire cfb_pkg::entry_t  head,
  input  wire logic             head_valid,
  output logic                  pop,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [7:0]            out_frame_byte,
  output logic                  out_frame_end,
  output logic                  out_run_last,
  output logic [1:0]            out_error_code
);

  logic [2:0]  step_r;
  logic [15:0] crc_r;
  logic [15:0] crc_nxt;
  logic        valid_r;
  logic [7:0]  byte_r;
  logic        end_r;
  logic        last_r;
  logic [1:0]  err_r;

  logic        fire;
  logic [2:0]  n_data;
  logic [2:0]  final_step;
  logic        in_data;
  logic        crc_hi;
  logic [7:0]  byte_nxt;
  logic        end_nxt;
  logic [1:0]  err_nxt;
  logic [7:0]  data_byte;
  logic [15:0] crc_base;

  assign fire = head_valid && (!valid_r || !out_stall);
  assign n_data = (head.kind == cfb_pkg::KIND_START) ? 3'd4 : 3'd1;
  assign final_step = n_data - 3'd1 + (head.close ? 3'd2 : 3'd0);
  assign in_data = (step_r < n_data);
  assign crc_hi = (step_r == n_data);
  assign pop = fire && (step_r == final_step);

  always_comb begin
    case (step_r)
      3'd0:    data_byte = head.cmd[15:8];
      3'd1:    data_byte = head.cmd[7:0];
      3'd2:    data_byte = head.len[15:8];
      3'd3:    data_byte = head.len[7:0];
      default: data_byte = 8'h00;
    endcase
  end

  always_comb begin
    crc_base = (step_r == 3'd0) ? cfb_pkg::CRC_INIT : crc_r;
    crc_nxt = crc_r;
    byte_nxt = 8'h00;
    end_nxt = 1'b0;
    err_nxt = cfb_pkg::ERR_NONE;
    case (head.kind)
      cfb_pkg::KIND_START, cfb_pkg::KIND_DATA: begin
        if (in_data) begin
          byte_nxt = (head.kind == cfb_pkg::KIND_START) ? data_byte : head.pbyte;
          crc_nxt = cfb_pkg::crc_byte(
              (head.kind == cfb_pkg::KIND_START) ? crc_base : crc_r, byte_nxt);
        end else if (crc_hi) begin
          byte_nxt = crc_r[15:8];
        end else begin
          byte_nxt = crc_r[7:0];
          end_nxt = 1'b1;
          crc_nxt = cfb_pkg::CRC_INIT;
        end
      end
      cfb_pkg::KIND_STRAY: begin
        err_nxt = cfb_pkg::ERR_STRAY;
      end
      cfb_pkg::KIND_LENGTH: begin
        err_nxt = cfb_pkg::ERR_LENGTH;
        crc_nxt = cfb_pkg::CRC_INIT;
      end
      default: begin
        err_nxt = cfb_pkg::ERR_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      byte_r <= byte_nxt;
      end_r <= end_nxt;
      last_r <= (step_r == final_step);
      err_r <= err_nxt;
    end
    if (!rst_n) begin
      step_r <= 3'd0;
      crc_r <= cfb_pkg::CRC_INIT;
      valid_r <= 1'b0;
    end else begin
      if (fire) begin
        crc_r <= crc_nxt;
        step_r <= pop ? 3'd0 : step_r + 3'd1;
        valid_r <= 1'b1;
      end else if (!out_stall) begin
        valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = valid_r;
  assign out_frame_byte = byte_r;
  assign out_frame_end = end_r;
  assign out_run_last = last_r;
  assign out_error_code = err_r;

endmodule

`default_nettype wire

@@ rtl/command_frame_builder_crc16.sv @@
// Top level of the command frame builder: front end, word queue and byte sequencer.
// An accepted word is registered in the queue; the sequencer then registers each of its result bytes.
// Throughput: one result byte per cycle while words are queued and out_stall is low; a payload word
// yields one byte, three when it closes the frame, and a start word four, six when its length is zero.
// The input stalls only while the four-entry queue is full. Reset (rst_n low, synchronous)
// empties the queue, closes any frame and sets the CRC to 0xFFFF.
`default_nettype none

`include "assert_macros.svh"

module command_frame_builder_crc16 (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_opcode,
  input  wire logic [15:0] in_command_code,
  input  wire logic [15:0] in_payload_length,
  input  wire logic [7:0]  in_payload_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_frame_byte,
  output logic             out_frame_end,
  output logic             out_run_last,
  output logic [1:0]       out_error_code
);

  logic            q_push;
  logic            q_pop;
  logic            q_full;
  logic            q_valid;
  cfb_pkg::entry_t q_entry;
  cfb_pkg::entry_t q_head;
  logic            end_ok;
  logic            err_ok;

  cfb_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_opcode         (in_opcode),
    .in_command_code   (in_command_code),
    .in_payload_length (in_payload_length),
    .in_payload_byte   (in_payload_byte),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_entry           (q_entry)
  );

  cfb_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .head       (q_head),
    .head_valid (q_valid),
    .full       (q_full)
  );

  cfb_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (q_head),
    .head_valid     (q_valid),
    .pop            (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_frame_byte (out_frame_byte),
    .out_frame_end  (out_frame_end),
    .out_run_last   (out_run_last),
    .out_error_code (out_error_code)
  );

  assign end_ok = !(out_valid && out_frame_end) || out_run_last;
  assign err_ok = !(out_valid && out_error_code != cfb_pkg::ERR_NONE)
                  || (out_run_last && !out_frame_end && out_frame_byte == 8'h00);

  `CFB_ASSERT(a_end_is_last, clk, rst_n, end_ok, "frame end without run last")
  `CFB_ASSERT(a_err_single, clk, rst_n, err_ok, "flagged result malformed")
  `CFB_ASSERT(a_pop_valid, clk, rst_n, !q_pop || q_valid, "queue popped while empty")
  `CFB_ASSERT_NEXT(a_pop_shows, clk, rst_n, q_pop, out_valid && out_run_last, "run not ended")

endmodule

`default_nettype wire

@@ test/frame_checker_pkg.sv @@
// Scoreboard class that predicts the frame byte stream and checks each output word.
package frame_checker_pkg;

  import cfb_pkg::*;

  localparam logic OP_START   = 1'b0;
  localparam logic OP_PAYLOAD = 1'b1;

  typedef struct {
    logic [7:0] fbyte;
    logic       fend;
    logic       last;
    logic [1:0] err;
  } frame_word_t;

  class frame_checker;
    frame_word_t      due_words[$];
    logic [15:0]      crc_acc;
    logic [REM_W-1:0] bytes_left;
    bit               frame_open;
    int               errors;

    function new();
      crc_acc    = CRC_INIT;
      bytes_left = '0;
      frame_open = 1'b0;
      errors     = 0;
    endfunction

    function int pending();
      return due_words.size();
    endfunction

    function logic [15:0] crc16_step(logic [15:0] crc, logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
        c = c[15] ? ((c << 1) ^ 16'h8005) : (c << 1);
      end
      return c;
    endfunction

    function void add_word(logic [7:0] b, logic e, logic [1:0] err);
      frame_word_t w;
      w.fbyte = b;
      w.fend  = e;
      w.last  = 1'b0;
      w.err   = err;
      due_words.push_back(w);
    endfunction

    function void add_data(logic [7:0] b);
      crc_acc = crc16_step(crc_acc, b);
      add_word(b, 1'b0, ERR_NONE);
    endfunction

    function void add_crc();
      add_word(crc_acc[15:8], 1'b0, ERR_NONE);
      add_word(crc_acc[7:0], 1'b1, ERR_NONE);
      crc_acc    = CRC_INIT;
      frame_open = 1'b0;
      bytes_left = '0;
    endfunction

    function void note_word(logic op, logic [15:0] cmd, logic [15:0] len, logic [7:0] pb);
      frame_word_t w;
      if (op == OP_START) begin
        crc_acc    = CRC_INIT;
        frame_open = 1'b0;
        bytes_left = '0;
        if (len > MAX_PAYLOAD) begin
          add_word(8'h00, 1'b0, ERR_LENGTH);
        end else begin
          add_data(cmd[15:8]);
          add_data(cmd[7:0]);
          add_data(len[15:8]);
          add_data(len[7:0]);
          if (len == 16'd0) begin
            add_crc();
          end else begin
            frame_open = 1'b1;
            bytes_left = len[REM_W-1:0];
          end
        end
      end else if (!frame_open) begin
        add_word(8'h00, 1'b0, ERR_STRAY);
      end else begin
        add_data(pb);
        bytes_left = bytes_left - 1'b1;
        if (bytes_left == '0) begin
          add_crc();
        end
      end
      w = due_words.pop_back();
      w.last = 1'b1;
      due_words.push_back(w);
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_word(logic [7:0] b, logic e, logic last, logic [1:0] err);
      frame_word_t w;
      if (due_words.size() == 0) begin
        report($sformatf("unexpected word byte=%02h end=%0b last=%0b err=%0d",
                         b, e, last, err));
        return;
      end
      w = due_words.pop_front();
      if (b !== w.fbyte) begin
        report($sformatf("frame_byte %02h, expected %02h", b, w.fbyte));
      end
      if (e !== w.fend) begin
        report($sformatf("frame_end %0b, expected %0b", e, w.fend));
      end
      if (last !== w.last) begin
        report($sformatf("run_last %0b, expected %0b", last, w.last));
      end
      if (err !== w.err) begin
        report($sformatf("error_code %0d, expected %0d", err, w.err));
      end
    endtask
  endclass

endpackage

@@ test/testbench.sv @@
// Top-level testbench for the command frame builder with directed and random frames.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cfb_pkg::*;
  import frame_checker_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_opcode = 1'b0;
  logic [15:0] in_command_code = '0;
  logic [15:0] in_payload_length = '0;
  logic [7:0]  in_payload_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_frame_byte;
  logic        out_frame_end;
  logic        out_run_last;
  logic [1:0]  out_error_code;

  frame_checker chk;
  bit           no_idle = 1'b0;
  int           word_count = 0;

  command_frame_builder_crc16 uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_opcode         (in_opcode),
    .in_command_code   (in_command_code),
    .in_payload_length (in_payload_length),
    .in_payload_byte   (in_payload_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_frame_byte    (out_frame_byte),
    .out_frame_end     (out_frame_end),
    .out_run_last      (out_run_last),
    .out_error_code    (out_error_code)
  );

  always #6 clk = ~clk;

  task send_word(logic op, logic [15:0] cmd, logic [15:0] len, logic [7:0] pb);
    while (!no_idle && $urandom_range(0, 99) < 22) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_opcode         <= op;
    in_command_code   <= cmd;
    in_payload_length <= len;
    in_payload_byte   <= pb;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    chk.note_word(op, cmd, len, pb);
    word_count++;
  endtask

  task send_start(logic [15:0] cmd, logic [15:0] len);
    send_word(OP_START, cmd, len, 8'($urandom));
  endtask

  task send_byte(logic [7:0] pb);
    send_word(OP_PAYLOAD, 16'($urandom), 16'($urandom), pb);
  endtask

  task send_frame(logic [15:0] len, int count);
    send_start(16'($urandom), len);
    for (int i = 0; i < count; i++) begin
      send_byte(8'($urandom));
    end
  endtask

  initial begin
    chk = new();
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        chk.check_word(out_frame_byte, out_frame_end, out_run_last, out_error_code);
      end
      out_stall <= !no_idle && ($urandom_range(0, 99) < 22);
    end
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    int goal;
    int kind;
    int len;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_byte(8'hFF);
    send_start(16'hFFFF, 16'd0);
    send_start(16'h0000, 16'd0);
    send_start(16'h1234, 16'(MAX_PAYLOAD + 1));
    send_start(16'hBEEF, 16'hFFFF);
    send_start(16'hA5C3, 16'd3);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h5A);
    send_start(16'h0102, 16'd1);
    send_byte(8'h80);
    send_start(16'h7E81, 16'd5);
    send_byte(8'h11);
    send_byte(8'h22);
    send_start(16'h00FF, 16'd1);
    send_byte(8'h7F);
    send_start(16'hFF00, 16'd2);
    send_byte(8'h01);
    send_start(16'h4242, 16'd300);
    send_byte(8'hAA);
    send_start(16'h5555, 16'd4);
    send_byte(8'hC3);
    send_start(16'hAAAA, 16'd0);

    goal = word_count + 140;
    while (word_count < goal) begin
      no_idle = (word_count > goal - 110) && (word_count < goal - 60);
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 6);
        send_frame(16'(len), len);
      end else if (kind < 78) begin
        send_byte(8'($urandom));
      end else if (kind < 86) begin
        send_start(16'($urandom), 16'($urandom_range(MAX_PAYLOAD + 1, 65535)));
      end else begin
        len = $urandom_range(2, 10);
        send_frame(16'(len), $urandom_range(1, len - 1));
      end
    end
    no_idle = 1'b0;
    send_frame(16'(MAX_PAYLOAD), 4);
    send_start(16'h3C3C, 16'd0);
    in_valid <= 1'b0;

    while (chk.pending() != 0) begin
      @(posedge clk);
    end
    repeat (10) @(posedge clk);
    if (chk.errors == 0 && chk.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
